// ----- src/tbkeg_pkg.sv -----
`timescale 1ns / 1ps

package tbkeg_pkg;

  localparam int SENSOR_COUNT  = 32;
  localparam int IDX_W         = $clog2(SENSOR_COUNT);
  localparam int KEY_REG_COUNT = 8;
  localparam int KEY_AW        = $clog2(KEY_REG_COUNT);
  localparam int CFG_DW        = 32;
  localparam int CODE_W        = 8;
  localparam int CODE_COUNT    = 1 << CODE_W;
  localparam int CNT_W         = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Default codes: '6'..'9', 'a'..'z', ',', '.'
  localparam logic [CFG_DW-1:0] KEY_RESET [KEY_REG_COUNT] = '{
    32'd959985462, 32'd1684234849, 32'd1751606885, 32'd1818978921,
    32'd1886350957, 32'd1953722993, 32'd2021095029, 32'd774666873
  };

  typedef struct packed {
    logic load;   // capture a new scan and start the sensor walk
    logic flush;  // emit the held event as the final one, then commit the map
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic flush_done;
  } sts_t;

  // Reverse the order of the four 2-bit pairs, keeping bit order within a pair
  function automatic logic [7:0] swap_pairs(input logic [7:0] b);
    swap_pairs = {b[1:0], b[3:2], b[5:4], b[7:6]};
  endfunction

endpackage

// ----- src/tbkeg_ctrl.sv -----
`timescale 1ns / 1ps

module tbkeg_ctrl import tbkeg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  assign in_ready_o  = in_ready_q;
  assign cmd_o.load  = in_valid_i && in_ready_q;
  assign cmd_o.flush = (state_q == S_FLUSH);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_WALK;
      S_WALK:  if (sts_i.walk_done) state_d = S_FLUSH;
      S_FLUSH: if (sts_i.flush_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == S_IDLE);
    end
  end

endmodule

// ----- src/tbkeg_datapath.sv -----
`timescale 1ns / 1ps

module tbkeg_datapath import tbkeg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [7:0]        touch_byte_a_i,
  input  logic [7:0]        touch_byte_b_i,
  input  logic [7:0]        touch_byte_c_i,
  input  logic [7:0]        touch_byte_d_i,
  input  logic              cfg_we_i,
  input  logic [KEY_AW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CODE_W-1:0] key_code_o,
  output logic              is_release_o,
  output logic              last_event_o
);

  logic [31:0]             map_full;
  logic [SENSOR_COUNT-1:0] map_q, prev_map_q;
  logic [CFG_DW-1:0]       key_regs_q [KEY_REG_COUNT];

  // Stage A: sensor index and memory read
  logic              a_act_q;
  logic [IDX_W-1:0]  a_idx_q;
  logic [CFG_DW-1:0] a_key;
  logic [CODE_W-1:0] a_code;

  // Stage B: count update and event decision
  logic              b_valid_q, b_rise_q, b_fall_q;
  logic [CODE_W-1:0] b_code_q;

  logic [CNT_W-1:0]  cnt_mem [CODE_COUNT];
  logic              cnt_vld_q [CODE_COUNT];
  logic [CNT_W-1:0]  rd_cnt_q;
  logic              rd_vld_q;

  logic              fwd_valid_q;
  logic [CODE_W-1:0] fwd_code_q;
  logic [CNT_W-1:0]  fwd_cnt_q;

  logic              pend_valid_q, pend_rel_q;
  logic [CODE_W-1:0] pend_code_q;

  logic              out_valid_q, out_rel_q, out_last_q;
  logic [CODE_W-1:0] out_code_q;

  logic [CNT_W-1:0]  cur_cnt, new_cnt;
  logic              cnt_we, b_event, stall, adv;
  logic              out_free, push_mid, push_last, flush_done;

  assign map_full = {swap_pairs(touch_byte_d_i), swap_pairs(touch_byte_c_i),
                     swap_pairs(touch_byte_b_i), swap_pairs(touch_byte_a_i)};

  assign a_key  = key_regs_q[KEY_AW'(a_idx_q >> 2)];
  assign a_code = a_key[{a_idx_q[1:0], 3'b000} +: CODE_W];

  always_comb begin
    if (fwd_valid_q && (fwd_code_q == b_code_q)) begin
      cur_cnt = fwd_cnt_q;
    end else if (rd_vld_q) begin
      cur_cnt = rd_cnt_q;
    end else begin
      cur_cnt = '0;
    end
    new_cnt = cur_cnt;
    cnt_we  = 1'b0;
    b_event = 1'b0;
    if (b_valid_q && b_rise_q) begin
      new_cnt = (cur_cnt == CNT_MAX) ? CNT_MAX : cur_cnt + CNT_W'(1);
      cnt_we  = 1'b1;
      b_event = 1'b1;
    end else if (b_valid_q && b_fall_q && (cur_cnt != '0)) begin
      new_cnt = cur_cnt - CNT_W'(1);
      cnt_we  = 1'b1;
      b_event = (cur_cnt == CNT_W'(1));
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign stall      = b_event && pend_valid_q && !out_free;
  assign adv        = !stall;
  assign push_mid   = adv && b_event && pend_valid_q;
  assign flush_done = !pend_valid_q || out_free;
  assign push_last  = cmd_i.flush && pend_valid_q && out_free;

  assign sts_o.walk_done  = !a_act_q && !b_valid_q;
  assign sts_o.flush_done = flush_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KEY_REG_COUNT; k++) begin
        key_regs_q[k] <= KEY_RESET[k];
      end
    end else if (cfg_we_i) begin
      key_regs_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      map_q <= map_full[SENSOR_COUNT-1:0];
    end
    if (adv) begin
      b_code_q <= a_code;
      b_rise_q <= map_q[a_idx_q] && !prev_map_q[a_idx_q];
      b_fall_q <= !map_q[a_idx_q] && prev_map_q[a_idx_q];
      rd_cnt_q <= cnt_mem[a_code];
    end
    if (adv && cnt_we) begin
      cnt_mem[b_code_q] <= new_cnt;
      fwd_code_q        <= b_code_q;
      fwd_cnt_q         <= new_cnt;
    end
    if (adv && b_event) begin
      pend_code_q <= b_code_q;
      pend_rel_q  <= b_fall_q;
    end
    if (push_mid || push_last) begin
      out_code_q <= pend_code_q;
      out_rel_q  <= pend_rel_q;
      out_last_q <= push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CODE_COUNT; k++) begin
        cnt_vld_q[k] <= 1'b0;
      end
      rd_vld_q <= 1'b0;
    end else if (adv) begin
      rd_vld_q <= cnt_vld_q[a_code];
      if (cnt_we) begin
        cnt_vld_q[b_code_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_map_q   <= '0;
      a_act_q      <= 1'b0;
      a_idx_q      <= '0;
      b_valid_q    <= 1'b0;
      fwd_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        a_act_q <= 1'b1;
        a_idx_q <= '0;
      end else if (adv && a_act_q) begin
        a_idx_q <= a_idx_q + IDX_W'(1);
        if (a_idx_q == IDX_W'(SENSOR_COUNT - 1)) begin
          a_act_q <= 1'b0;
        end
      end
      if (adv) begin
        b_valid_q <= a_act_q;
      end
      if (adv && cnt_we) begin
        fwd_valid_q <= 1'b1;
      end
      if (adv && b_event) begin
        pend_valid_q <= 1'b1;
      end else if (push_last) begin
        pend_valid_q <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.flush && flush_done) begin
        prev_map_q <= map_q;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_code_o   = out_code_q;
  assign is_release_o = out_rel_q;
  assign last_event_o = out_last_q;

endmodule

// ----- src/touch_bitmap_key_event_generator.sv -----
`timescale 1ns / 1ps
// Event path: an event is held until the next one of its scan is found, or until the flush
//   for the final one; it passes stage A, stage B and the hold register to the output register.
// Throughput: one scan at a time, the next accepted only once the held event is flushed;
//   one sensor per cycle, stalled only when a new event meets a waiting one and output is full.
// Reset: previous map cleared, press counts read as zero, key codes return to defaults.
// Press counts live in a 256 x 6 memory; per-entry valid flops clear at reset at once.

module touch_bitmap_key_event_generator import tbkeg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // scan input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        touch_byte_a_i,
  input  logic [7:0]        touch_byte_b_i,
  input  logic [7:0]        touch_byte_c_i,
  input  logic [7:0]        touch_byte_d_i,
  // key code register writes
  input  logic              cfg_we_i,
  input  logic [KEY_AW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  // key events
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CODE_W-1:0] key_code_o,
  output logic              is_release_o,
  output logic              last_event_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: accept a scan, wait for the sensor walk, then flush the held event
  // with its final-event mark before accepting the next transaction.
  tbkeg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Datapath: pair-swapped map capture, edge detection per sensor, press count
  // read-modify-write with forwarding, one-deep hold of the latest event so the
  // last one of a scan can be marked, and the output register.
  tbkeg_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .touch_byte_a_i (touch_byte_a_i),
    .touch_byte_b_i (touch_byte_b_i),
    .touch_byte_c_i (touch_byte_c_i),
    .touch_byte_d_i (touch_byte_d_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .key_code_o     (key_code_o),
    .is_release_o   (is_release_o),
    .last_event_o   (last_event_o)
  );

endmodule

// ----- src/tbkeg_checker.sv -----
`timescale 1ns / 1ps

module tbkeg_checker import tbkeg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [CODE_W-1:0] key_code_o,
  input logic              is_release_o,
  input logic              last_event_o
);

  // A held event keeps its payload until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_code_o)
      && $stable(is_release_o) && $stable(last_event_o))
    else $error("event changed while stalled");

  // One scan at a time: ready drops after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready held after scan accepted");

  // Idle block stays idle without a new scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !in_valid_i |=> in_ready_o)
    else $error("ready dropped while idle");

  // While idle only the final event of the previous scan may be waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> last_event_o)
    else $error("non-final event pending while idle");

endmodule

bind touch_bitmap_key_event_generator tbkeg_checker u_tbkeg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .key_code_o   (key_code_o),
  .is_release_o (is_release_o),
  .last_event_o (last_event_o)
);

// ----- verif/key_event_checker.sv -----
`timescale 1ns / 1ps

module key_event_checker import tbkeg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              scan_valid_i,
  input  logic              scan_ready_i,
  input  logic [7:0]        touch_a_i,
  input  logic [7:0]        touch_b_i,
  input  logic [7:0]        touch_c_i,
  input  logic [7:0]        touch_d_i,
  input  logic              cfg_we_i,
  input  logic [KEY_AW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              event_valid_i,
  input  logic              event_ready_i,
  input  logic [CODE_W-1:0] key_code_i,
  input  logic              is_release_i,
  input  logic              last_event_i,
  output int                mismatch_count_o,
  output int                events_pending_o
);

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              is_release;
    logic              last_event;
  } key_event_t;

  logic [CFG_DW-1:0] key_regs [KEY_REG_COUNT];
  logic [CNT_W-1:0]  press_level [CODE_COUNT];
  logic [31:0]       held_map;
  key_event_t        awaited_events [$];
  int                awaited_level = 0;
  int                mismatches = 0;

  assign mismatch_count_o = mismatches;
  assign events_pending_o = awaited_level;

  task automatic report_mismatch(input string what);
    $display("%0t ns: key event check: %s", $realtime, what);
    mismatches++;
  endtask

  // Pair k of the result takes pair 3-k of the chip byte
  function automatic logic [7:0] reverse_pairs(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 4; k++) r[2*k +: 2] = b[6-2*k +: 2];
    return r;
  endfunction

  // Walk the sensors in ascending order and queue the events of one scan
  task automatic walk_scan(input logic [31:0] map_in);
    key_event_t        found [$];
    key_event_t        ev;
    logic [CODE_W-1:0] code;
    logic              now_on;
    logic              was_on;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      code   = key_regs[i / 4][(i % 4) * CODE_W +: CODE_W];
      now_on = map_in[i];
      was_on = held_map[i];
      ev.code       = code;
      ev.last_event = 1'b0;
      if (now_on && !was_on) begin
        if (press_level[code] != CNT_MAX) press_level[code] = press_level[code] + 1'b1;
        ev.is_release = 1'b0;
        found.push_back(ev);
      end else if (!now_on && was_on && press_level[code] != '0) begin
        press_level[code] = press_level[code] - 1'b1;
        if (press_level[code] == '0) begin
          ev.is_release = 1'b1;
          found.push_back(ev);
        end
      end
    end
    if (found.size() > 0) found[found.size() - 1].last_event = 1'b1;
    foreach (found[k]) awaited_events.push_back(found[k]);
    held_map = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) held_map[i] = map_in[i];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    key_event_t head;
    if (!rst_ni) begin
      for (int r = 0; r < KEY_REG_COUNT; r++) key_regs[r] = KEY_RESET[r];
      for (int c = 0; c < CODE_COUNT; c++) press_level[c] = '0;
      held_map = '0;
      awaited_events.delete();
      awaited_level = 0;
    end else begin
      if (cfg_we_i && cfg_index_i < KEY_REG_COUNT) key_regs[cfg_index_i] = cfg_wdata_i;
      if (scan_valid_i && scan_ready_i)
        walk_scan({reverse_pairs(touch_d_i), reverse_pairs(touch_c_i),
                   reverse_pairs(touch_b_i), reverse_pairs(touch_a_i)});
      if (event_valid_i && event_ready_i) begin
        if (awaited_events.size() == 0) begin
          report_mismatch($sformatf("code %02h arrived with nothing awaited", key_code_i));
        end else begin
          head = awaited_events.pop_front();
          if (key_code_i !== head.code)
            report_mismatch($sformatf("key_code %02h, awaited %02h", key_code_i, head.code));
          if (is_release_i !== head.is_release)
            report_mismatch($sformatf("is_release %b, awaited %b (code %02h)",
                                      is_release_i, head.is_release, head.code));
          if (last_event_i !== head.last_event)
            report_mismatch($sformatf("last_event %b, awaited %b (code %02h)",
                                      last_event_i, head.last_event, head.code));
        end
      end
      awaited_level = awaited_events.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import tbkeg_pkg::*;

  // Longest stretch without any transaction before the run is declared hung.
  // The deliberate receiver hold-off is the longest legal quiet stretch.
  localparam int WATCHDOG_LIMIT = 3000;
  // Cycles to let a scan with no events finish its walk
  localparam int DRAIN_CYCLES   = 40;
  localparam int SQUEEZE_AT     = 100;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int PHASE_ITEMS    = 44;

  typedef enum int {
    CODES_DEFAULT,
    CODES_FILL,
    CODES_RANDOM,
    CODES_FEW
  } code_plan_e;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        touch_byte_a_i;
  logic [7:0]        touch_byte_b_i;
  logic [7:0]        touch_byte_c_i;
  logic [7:0]        touch_byte_d_i;
  logic              cfg_we_i;
  logic [KEY_AW-1:0] cfg_index_i;
  logic [CFG_DW-1:0] cfg_wdata_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [CODE_W-1:0] key_code_o;
  logic              is_release_o;
  logic              last_event_o;

  int          mismatch_count;
  int          events_pending;
  int          idle_cycles;
  int unsigned events_taken;
  bit          sender_calm;
  bit          receiver_calm;
  logic [31:0] touch_now;

  touch_bitmap_key_event_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .touch_byte_a_i (touch_byte_a_i),
    .touch_byte_b_i (touch_byte_b_i),
    .touch_byte_c_i (touch_byte_c_i),
    .touch_byte_d_i (touch_byte_d_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .key_code_o     (key_code_o),
    .is_release_o   (is_release_o),
    .last_event_o   (last_event_o)
  );

  key_event_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .scan_valid_i     (in_valid_i),
    .scan_ready_i     (in_ready_o),
    .touch_a_i        (touch_byte_a_i),
    .touch_b_i        (touch_byte_b_i),
    .touch_c_i        (touch_byte_c_i),
    .touch_d_i        (touch_byte_d_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .event_valid_i    (out_valid_o),
    .event_ready_i    (out_ready_i),
    .key_code_i       (key_code_o),
    .is_release_i     (is_release_o),
    .last_event_i     (last_event_o),
    .mismatch_count_o (mismatch_count),
    .events_pending_o (events_pending)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Watchdog: count cycles in which neither channel completes a transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one scan after a random gap and hold it until the block takes it.
  // Valid is only lowered when a gap follows, so back-to-back scans keep it high.
  task automatic offer_scan(input logic [31:0] bytes);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    touch_byte_a_i <= bytes[7:0];
    touch_byte_b_i <= bytes[15:8];
    touch_byte_c_i <= bytes[23:16];
    touch_byte_d_i <= bytes[31:24];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait for every awaited event, then let a silent walk finish
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (events_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Rewrite all eight key code registers; only call when the block is idle
  task automatic load_codes(input code_plan_e plan, input logic [7:0] fill);
    logic [CFG_DW-1:0] value;
    for (int r = 0; r < KEY_REG_COUNT; r++) begin
      case (plan)
        CODES_DEFAULT: value = KEY_RESET[r];
        CODES_FILL:    value = {4{fill}};
        CODES_RANDOM:  value = $urandom();
        default: begin
          // Codes 0 to 3 only: heavy sharing of press counts between sensors
          for (int k = 0; k < 4; k++) value[8*k +: 8] = $urandom_range(0, 3);
        end
      endcase
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= r[KEY_AW-1:0];
      cfg_wdata_i <= value;
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Advance the touch pattern: mostly a few fingers move, sometimes a jump
  task automatic next_touch();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      repeat ($urandom_range(1, 3)) touch_now[$urandom_range(0, 31)] ^= 1'b1;
    end else if (pick < 85) begin
      touch_now = $urandom();
    end else if (pick < 91) begin
      touch_now = '0;
    end else if (pick < 96) begin
      touch_now = '1;
    end
  endtask

  // Receiver: random stalls per event, calm stretches, and one long hold-off
  // while the sender keeps offering scans so that the block backs up.
  initial begin
    out_ready_i   = 1'b0;
    receiver_calm = 1'b0;
    events_taken  = 0;
    wait (rst_ni);
    forever begin : take_events
      int unsigned stall;
      if (events_taken % 16 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
      stall = receiver_calm ? 0 : $urandom_range(0, 11);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      events_taken++;
      if (events_taken == SQUEEZE_AT) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk_i);
      end
    end
  end

  initial begin
    code_plan_e plans [6];
    logic [7:0] fills [6];

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    touch_byte_a_i = '0;
    touch_byte_b_i = '0;
    touch_byte_c_i = '0;
    touch_byte_d_i = '0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_wdata_i    = '0;
    sender_calm    = 1'b0;
    touch_now      = '0;
    plans = '{CODES_RANDOM, CODES_FILL, CODES_FEW, CODES_FILL, CODES_DEFAULT, CODES_RANDOM};
    fills = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: no change, every sensor pressed and released, pair ordering
    offer_scan(32'h0000_0000);
    offer_scan(32'hFFFF_FFFF);
    offer_scan(32'hFFFF_FFFF);
    offer_scan(32'h0000_0000);
    offer_scan(32'h8040_0201);
    offer_scan(32'h55AA_0FF0);
    offer_scan(32'hAA55_F00F);
    offer_scan(32'h0000_0000);

    // Shared code: only the last sensor released gives the release event
    wait_idle();
    load_codes(CODES_FILL, 8'hC3);
    offer_scan(32'hFFFF_FFFF);
    offer_scan(32'h0000_0000);
    offer_scan(32'hFFFF_FFFF);

    // Change codes while held: releases hit a zero count and stay silent
    wait_idle();
    load_codes(CODES_FILL, 8'h3C);
    offer_scan(32'h0000_0000);

    // Press the same code again: the count saturates, then no release at all
    wait_idle();
    load_codes(CODES_FILL, 8'hC3);
    offer_scan(32'hFFFF_FFFF);
    offer_scan(32'h0000_0000);

    // Random phases, each under a fresh key code setting
    foreach (plans[p]) begin
      wait_idle();
      load_codes(plans[p], fills[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 16 == 0) sender_calm = ($urandom_range(0, 3) == 0);
        next_touch();
        offer_scan(touch_now);
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
